[design/erfinv_pkg.sv]
// ----------------------------------------------------------------------------
// erfinv_pkg
// Shared types, constants and helper functions for the binary32 erfinv core.
// ----------------------------------------------------------------------------
package erfinv_pkg;

    localparam logic [31:0] F_ONE        = 32'h3F800000;
    localparam logic [31:0] F_NEG_ONE    = 32'hBF800000;
    localparam logic [31:0] F_NEG_ZERO   = 32'h80000000;
    localparam logic [31:0] F_POS_INF    = 32'h7F800000;
    localparam logic [31:0] F_NEG_INF    = 32'hFF800000;
    localparam logic [31:0] F_QNAN       = 32'h7FC00000;
    localparam logic [31:0] F_QBIT       = 32'h00400000;
    localparam logic [31:0] F_TWO_THIRDS = 32'h3F2AAAAB;
    localparam logic [31:0] F_MAX        = 32'h7F7FFFFF;
    localparam logic [31:0] F_LN2        = 32'h3F317218;
    localparam logic [31:0] F_SPLIT      = 32'h40C40000;
    localparam logic [31:0] F_HALF_NEG   = 32'hBF000000;
    localparam logic [31:0] F_L_THIRD    = 32'h3EAAAA7D;

    localparam logic [31:0] LOG_R0 = 32'hBE057000;
    localparam logic [31:0] LOG_R1 = 32'hBDF8CCB4;
    localparam logic [31:0] LOG_R2 = 32'hBE2AD9B1;
    localparam logic [31:0] LOG_R3 = 32'hBE7FFF01;
    localparam logic [31:0] LOG_T0 = 32'h3E104000;
    localparam logic [31:0] LOG_T1 = 32'h3E0F2BA0;
    localparam logic [31:0] LOG_T2 = 32'h3E4CEC59;

    localparam int N_TAIL = 9;
    localparam int N_MID  = 10;

    localparam logic [31:0] POLY_TAIL [N_TAIL] = '{
        32'h2FA6F5A2, 32'h32FBE4D7, 32'h35A3F289, 32'h37EE53EF, 32'h39CE55C9,
        32'h3B46606F, 32'h3B9E5490, 32'hBE877FB3, 32'h3F570B52
    };
    localparam logic [31:0] POLY_MID [N_MID] = '{
        32'h31BAE000, 32'h3419DA01, 32'h35A4C919, 32'h33F29669, 32'hB86B85E8,
        32'hB91ADF48, 32'h3B17B200, 32'h3C3D0F28, 32'hBE6D9577, 32'h3F62DFC4
    };

    // fma unit depth and fma stages on the longest path
    localparam int FMA_LAT = 4;
    localparam int N_FMA   = 21;
    // input register + log prep register + fma chain
    localparam int LATENCY = 2 + FMA_LAT * N_FMA;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] fi;
        logic        spec;
        logic [31:0] spec_val;
        logic [31:0] mq;
        logic [31:0] s;
        logic [31:0] te;
        logic [31:0] tl;
        logic        tail;
    } side_t;

    typedef struct packed {
        logic [23:0]        sig;
        logic signed [11:0] ex;
    } unp_t;

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:0] > F_POS_INF[30:0];
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:0] == F_POS_INF[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 6'(63 - i);
        end
        return n;
    endfunction

    // finite nonzero x = sig * 2^ex, sig normalized to bit 23
    function automatic unp_t unpack(input logic [31:0] x);
        unp_t u;
        logic [23:0] s;
        logic [4:0] lz;
        s = {|x[30:23], x[22:0]};
        lz = lzc24(s);
        u.sig = s << lz;
        if (x[30:23] == 8'd0) u.ex = -12'sd149;
        else u.ex = $signed({4'b0, x[30:23]}) - 12'sd150;
        u.ex = u.ex - $signed({7'b0, lz});
        return u;
    endfunction

    // small signed integer to binary32, exact
    function automatic logic [31:0] int_to_f32(input logic signed [11:0] v);
        logic [11:0] mag;
        logic [7:0] u;
        logic [2:0] p;
        logic [30:0] w;
        mag = v[11] ? 12'(-v) : 12'(v);
        u = mag[7:0];
        p = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (u[i]) p = 3'(i);
        end
        w = {23'b0, u} << (5'd23 - {2'b0, p});
        if (v == 12'sd0) return 32'd0;
        return {v[11], 8'(8'd127 + {5'b0, p}), w[22:0]};
    endfunction

endpackage

[design/erfinv_fma.sv]
// ----------------------------------------------------------------------------
// erfinv_fma
// Four-stage binary32 fused multiply-add, one rounding to nearest even.
// ----------------------------------------------------------------------------
module erfinv_fma (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld_in,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    input  logic [31:0]         c,
    input  erfinv_pkg::side_t   side_in,
    output logic                vld_out,
    output logic [31:0]         res,
    output erfinv_pkg::side_t   side_out
);

    // stage 1: specials, unpack, multiply
    logic               spec_next;
    logic [31:0]        sv_next;
    logic               sp_next;
    erfinv_pkg::unp_t   ua, ub, uc;

    logic               v1_reg, spec1_reg, sp1_reg, sc1_reg, zc1_reg;
    logic [31:0]        sv1_reg;
    logic [47:0]        prod1_reg;
    logic signed [11:0] ep1_reg, ec1_reg;
    logic [23:0]        mc1_reg;
    erfinv_pkg::side_t  side1_reg;

    always_comb
    begin
        ua = erfinv_pkg::unpack(a);
        ub = erfinv_pkg::unpack(b);
        uc = erfinv_pkg::unpack(c);
        sp_next = a[31] ^ b[31];
        spec_next = 1'b1;
        sv_next = erfinv_pkg::F_QNAN;
        if (erfinv_pkg::is_nan(a)) sv_next = a | erfinv_pkg::F_QBIT;
        else if (erfinv_pkg::is_nan(b)) sv_next = b | erfinv_pkg::F_QBIT;
        else if (erfinv_pkg::is_nan(c)) sv_next = c | erfinv_pkg::F_QBIT;
        else if (erfinv_pkg::is_inf(a) || erfinv_pkg::is_inf(b))
        begin
            if (erfinv_pkg::is_zero(a) || erfinv_pkg::is_zero(b))
                sv_next = erfinv_pkg::F_QNAN;
            else if (erfinv_pkg::is_inf(c) && (c[31] != sp_next))
                sv_next = erfinv_pkg::F_QNAN;
            else
                sv_next = {sp_next, erfinv_pkg::F_POS_INF[30:0]};
        end
        else if (erfinv_pkg::is_inf(c)) sv_next = c;
        else if (erfinv_pkg::is_zero(a) || erfinv_pkg::is_zero(b))
        begin
            if (erfinv_pkg::is_zero(c)) sv_next = {sp_next & c[31], 31'd0};
            else sv_next = c;
        end
        else spec_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else v1_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        spec1_reg <= spec_next;
        sv1_reg   <= sv_next;
        prod1_reg <= ua.sig * ub.sig;
        ep1_reg   <= ua.ex + ub.ex - 12'sd14;
        sp1_reg   <= sp_next;
        mc1_reg   <= uc.sig;
        ec1_reg   <= uc.ex - 12'sd38;
        sc1_reg   <= c[31];
        zc1_reg   <= erfinv_pkg::is_zero(c);
        side1_reg <= side_in;
    end

    // stage 2: align with sticky, add or subtract
    logic [63:0]        x2, y2, r2_next, mask2;
    logic signed [11:0] ex2, d2;
    logic               sx2, sy2, sr2_next;

    logic               v2_reg, spec2_reg, sr2_reg, rz2_reg;
    logic [31:0]        sv2_reg;
    logic [63:0]        r2_reg;
    logic signed [11:0] ex2_reg;
    erfinv_pkg::side_t  side2_reg;

    always_comb
    begin
        if (zc1_reg || (ep1_reg >= ec1_reg))
        begin
            x2 = {2'b0, prod1_reg, 14'b0};
            ex2 = ep1_reg;
            sx2 = sp1_reg;
            y2 = zc1_reg ? 64'd0 : {2'b0, mc1_reg, 38'b0};
            sy2 = zc1_reg ? sp1_reg : sc1_reg;
            d2 = zc1_reg ? 12'sd0 : (ep1_reg - ec1_reg);
        end
        else
        begin
            x2 = {2'b0, mc1_reg, 38'b0};
            ex2 = ec1_reg;
            sx2 = sc1_reg;
            y2 = {2'b0, prod1_reg, 14'b0};
            sy2 = sp1_reg;
            d2 = ec1_reg - ep1_reg;
        end
        mask2 = ~({64{1'b1}} << d2[5:0]);
        if (d2 > 12'sd63) y2 = 64'd1;
        else if (d2 > 12'sd0) y2 = (y2 >> d2[5:0]) | {63'd0, |(y2 & mask2)};
        sr2_next = sx2;
        if (sx2 == sy2) r2_next = x2 + y2;
        else if (x2 >= y2) r2_next = x2 - y2;
        else
        begin
            r2_next = y2 - x2;
            sr2_next = sy2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        spec2_reg <= spec1_reg;
        sv2_reg   <= sv1_reg;
        r2_reg    <= r2_next;
        rz2_reg   <= (r2_next == 64'd0);
        sr2_reg   <= sr2_next;
        ex2_reg   <= ex2;
        side2_reg <= side1_reg;
    end

    // stage 3: normalize
    logic [5:0]         lz3;
    logic               v3_reg, spec3_reg, sr3_reg, rz3_reg;
    logic [31:0]        sv3_reg;
    logic [63:0]        rn3_reg;
    logic signed [11:0] bias3_reg;
    erfinv_pkg::side_t  side3_reg;

    assign lz3 = erfinv_pkg::lzc64(r2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        spec3_reg <= spec2_reg;
        sv3_reg   <= sv2_reg;
        rz3_reg   <= rz2_reg;
        sr3_reg   <= sr2_reg;
        rn3_reg   <= r2_reg << lz3;
        bias3_reg <= ex2_reg - $signed({6'b0, lz3}) + 12'sd190;
        side3_reg <= side2_reg;
    end

    // stage 4: round and pack
    logic signed [11:0] shm1;
    logic [7:0]         base4;
    logic [63:0]        q4;
    logic               sticky4, up4;
    logic [30:0]        bits4;
    logic [31:0]        res_next;

    logic               v4_reg;
    logic [31:0]        res4_reg;
    erfinv_pkg::side_t  side4_reg;

    always_comb
    begin
        if (bias3_reg >= 12'sd1)
        begin
            shm1 = 12'sd39;
            base4 = 8'(bias3_reg - 12'sd1);
        end
        else
        begin
            shm1 = 12'sd40 - bias3_reg;
            base4 = 8'd0;
        end
        q4 = rn3_reg >> shm1[5:0];
        sticky4 = |(rn3_reg & ~({64{1'b1}} << shm1[5:0]));
        up4 = q4[0] & (sticky4 | q4[1]);
        bits4 = {base4, 23'd0} + {7'd0, q4[24:1]} + {30'd0, up4};
        if (spec3_reg) res_next = sv3_reg;
        else if (rz3_reg) res_next = 32'd0;
        else if (bias3_reg > 12'sd254) res_next = {sr3_reg, erfinv_pkg::F_POS_INF[30:0]};
        else if (shm1 > 12'sd63) res_next = {sr3_reg, 31'd0};
        else res_next = {sr3_reg, bits4};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        res4_reg  <= res_next;
        side4_reg <= side3_reg;
    end

    assign vld_out  = v4_reg;
    assign res      = res4_reg;
    assign side_out = side4_reg;

endmodule

[design/inverse_error_function_fp32_core.sv]
// ----------------------------------------------------------------------------
// inverse_error_function_fp32_core
// Fully pipelined binary32 erfinv built from a chain of fma units.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operand_bits and pulse start; an item is taken at every clock edge
//   where start is high and busy is low. busy stays low, so one item can be
//   issued every cycle.
//   Each result appears on result_bits for one cycle with done high, in
//   issue order.
//   Latency: one input register, 21 fma units of 4 stages each on the
//   longest path (1 - a*a, log1p chain, Horner, final multiply), plus one
//   register that prepares the log argument.
//   Throughput: one item per cycle; every fma unit is fully pipelined.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall: done is a strobe and results are not held.
// ----------------------------------------------------------------------------
module inverse_error_function_fp32_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] operand_bits,
    output logic        done,
    output logic [31:0] result_bits
);

    assign busy = 1'b0;

    // input register
    logic        in_vld_reg;
    logic [31:0] a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) in_vld_reg <= 1'b0;
        else in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_reg <= operand_bits;
    end

    // -a with NaN quieted and zero as +0
    logic [31:0] neg_a, na;
    erfinv_pkg::side_t s0_side_in;

    always_comb
    begin
        neg_a = a_reg ^ 32'h80000000;
        if (erfinv_pkg::is_nan(neg_a)) na = neg_a | erfinv_pkg::F_QBIT;
        else if (erfinv_pkg::is_zero(neg_a)) na = 32'd0;
        else na = neg_a;
        s0_side_in = '0;
        s0_side_in.a = a_reg;
    end

    logic s0_vld;
    logic [31:0] s0_res;
    erfinv_pkg::side_t s0_side;

    erfinv_fma u_s0 (
        .clk(clk), .rst_n(rst_n), .vld_in(in_vld_reg),
        .a(a_reg), .b(na), .c(erfinv_pkg::F_ONE), .side_in(s0_side_in),
        .vld_out(s0_vld), .res(s0_res), .side_out(s0_side)
    );

    // log argument prep: specials, exponent split, reduction to [2/3, 4/3)
    logic [4:0]         pk;
    logic [23:0]        pf;
    logic [31:0]        m_next;
    logic signed [11:0] e_next;
    erfinv_pkg::side_t  pre_side_next;

    logic               pre_vld_reg;
    logic [31:0]        pre_m_reg;
    erfinv_pkg::side_t  pre_side_reg;

    always_comb
    begin
        pre_side_next = s0_side;
        pre_side_next.spec = (s0_res == 32'd0) || (s0_res > erfinv_pkg::F_MAX);
        if (erfinv_pkg::is_nan(s0_res)) pre_side_next.spec_val = s0_res | erfinv_pkg::F_QBIT;
        else if (erfinv_pkg::is_zero(s0_res)) pre_side_next.spec_val = erfinv_pkg::F_NEG_INF;
        else if (s0_res[31]) pre_side_next.spec_val = erfinv_pkg::F_QNAN;
        else pre_side_next.spec_val = erfinv_pkg::F_POS_INF;
        pk = erfinv_pkg::lzc24({1'b0, s0_res[22:0]});
        pf = {1'b0, s0_res[22:0]} << pk;
        if (s0_res[30:23] != 8'd0)
        begin
            m_next = {1'b0, 8'd126, s0_res[22:0]};
            e_next = $signed({4'b0, s0_res[30:23]}) - 12'sd126;
        end
        else
        begin
            m_next = {1'b0, 8'd126, pf[22:0]};
            e_next = -12'sd125 - $signed({7'b0, pk});
        end
        if (m_next < erfinv_pkg::F_TWO_THIRDS)
        begin
            m_next = m_next + 32'h00800000;
            e_next = e_next - 12'sd1;
        end
        pre_side_next.fi = erfinv_pkg::int_to_f32(e_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pre_vld_reg <= 1'b0;
        else pre_vld_reg <= s0_vld;
    end

    always_ff @(posedge clk)
    begin
        pre_m_reg    <= m_next;
        pre_side_reg <= pre_side_next;
    end

    // log1p chain
    logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld, s9_vld, s10_vld;
    logic s3t_vld, s4t_vld;
    logic [31:0] s1_res, s2_res, s3_res, s3t_res, s4_res, s4t_res;
    logic [31:0] s5_res, s6_res, s7_res, s8_res, s9_res, s10_res;
    erfinv_pkg::side_t s1_side, s2_side, s3_side, s4_side, s5_side;
    erfinv_pkg::side_t s6_side, s7_side, s8_side, s9_side, s10_side;
    erfinv_pkg::side_t s2_side_in, s3_side_in, s6_side_in;

    // even-chain value waits in the te_hold_reg delay line alongside u_s5, then goes into te
    logic [31:0] te_hold_reg [erfinv_pkg::FMA_LAT];

    always_comb
    begin
        s2_side_in = s1_side;
        s2_side_in.mq = s1_res;
        s3_side_in = s2_side;
        s3_side_in.s = s2_res;
        s6_side_in = s5_side;
        s6_side_in.te = te_hold_reg[erfinv_pkg::FMA_LAT-1];
    end

    erfinv_fma u_s1 (
        .clk(clk), .rst_n(rst_n), .vld_in(pre_vld_reg),
        .a(pre_m_reg), .b(erfinv_pkg::F_ONE), .c(erfinv_pkg::F_NEG_ONE),
        .side_in(pre_side_reg), .vld_out(s1_vld), .res(s1_res), .side_out(s1_side)
    );

    erfinv_fma u_s2 (
        .clk(clk), .rst_n(rst_n), .vld_in(s1_vld),
        .a(s1_res), .b(s1_res), .c(erfinv_pkg::F_NEG_ZERO),
        .side_in(s2_side_in), .vld_out(s2_vld), .res(s2_res), .side_out(s2_side)
    );

    erfinv_fma u_s3r (
        .clk(clk), .rst_n(rst_n), .vld_in(s2_vld),
        .a(erfinv_pkg::LOG_R0), .b(s2_res), .c(erfinv_pkg::LOG_R1),
        .side_in(s3_side_in), .vld_out(s3_vld), .res(s3_res), .side_out(s3_side)
    );

    erfinv_fma u_s3t (
        .clk(clk), .rst_n(rst_n), .vld_in(s2_vld),
        .a(erfinv_pkg::LOG_T0), .b(s2_res), .c(erfinv_pkg::LOG_T1),
        .side_in('0), .vld_out(s3t_vld), .res(s3t_res), .side_out()
    );

    erfinv_fma u_s4r (
        .clk(clk), .rst_n(rst_n), .vld_in(s3_vld),
        .a(s3_res), .b(s3_side.s), .c(erfinv_pkg::LOG_R2),
        .side_in(s3_side), .vld_out(s4_vld), .res(s4_res), .side_out(s4_side)
    );

    erfinv_fma u_s4t (
        .clk(clk), .rst_n(rst_n), .vld_in(s3t_vld),
        .a(s3t_res), .b(s3_side.s), .c(erfinv_pkg::LOG_T2),
        .side_in('0), .vld_out(s4t_vld), .res(s4t_res), .side_out()
    );

    erfinv_fma u_s5 (
        .clk(clk), .rst_n(rst_n), .vld_in(s4_vld && s4t_vld),
        .a(s4_res), .b(s4_side.s), .c(erfinv_pkg::LOG_R3),
        .side_in(s4_side), .vld_out(s5_vld), .res(s5_res), .side_out(s5_side)
    );

    always_ff @(posedge clk)
    begin
        te_hold_reg[0] <= s4t_res;
        for (int i = 1; i < erfinv_pkg::FMA_LAT; i++) te_hold_reg[i] <= te_hold_reg[i-1];
    end

    erfinv_fma u_s6 (
        .clk(clk), .rst_n(rst_n), .vld_in(s5_vld),
        .a(te_hold_reg[erfinv_pkg::FMA_LAT-1]), .b(s5_side.mq), .c(s5_res),
        .side_in(s6_side_in), .vld_out(s6_vld), .res(s6_res), .side_out(s6_side)
    );

    erfinv_fma u_s7 (
        .clk(clk), .rst_n(rst_n), .vld_in(s6_vld),
        .a(s6_res), .b(s6_side.mq), .c(erfinv_pkg::F_L_THIRD),
        .side_in(s6_side), .vld_out(s7_vld), .res(s7_res), .side_out(s7_side)
    );

    erfinv_fma u_s8 (
        .clk(clk), .rst_n(rst_n), .vld_in(s7_vld),
        .a(s7_res), .b(s7_side.mq), .c(erfinv_pkg::F_HALF_NEG),
        .side_in(s7_side), .vld_out(s8_vld), .res(s8_res), .side_out(s8_side)
    );

    erfinv_fma u_s9 (
        .clk(clk), .rst_n(rst_n), .vld_in(s8_vld),
        .a(s8_res), .b(s8_side.s), .c(s8_side.mq),
        .side_in(s8_side), .vld_out(s9_vld), .res(s9_res), .side_out(s9_side)
    );

    erfinv_fma u_s10 (
        .clk(clk), .rst_n(rst_n), .vld_in(s9_vld),
        .a(s9_side.fi), .b(erfinv_pkg::F_LN2), .c(s9_res),
        .side_in(s9_side), .vld_out(s10_vld), .res(s10_res), .side_out(s10_side)
    );

    // log value and polynomial select
    logic [31:0] log_val;
    logic [30:0] log_mag;
    erfinv_pkg::side_t  p0_side;
    logic               p_vld  [erfinv_pkg::N_TAIL+1];
    logic [31:0]        p_res  [erfinv_pkg::N_TAIL+1];
    erfinv_pkg::side_t  p_side [erfinv_pkg::N_TAIL+1];

    always_comb
    begin
        log_val = s10_side.spec ? s10_side.spec_val : s10_res;
        log_mag = log_val[30:0];
        p0_side = s10_side;
        p0_side.tl = log_val;
        p0_side.tail = (log_mag > erfinv_pkg::F_SPLIT[30:0])
                    && (log_mag <= erfinv_pkg::F_POS_INF[30:0]);
    end

    assign p_vld[0]  = s10_vld;
    assign p_res[0]  = log_val;
    assign p_side[0] = p0_side;

    // Horner: the tail path spends its first unit loading its lead coefficient
    for (genvar k = 0; k < erfinv_pkg::N_TAIL; k++)
    begin : g_poly
        logic [31:0] fa, fb, fc;

        always_comb
        begin
            if (k == 0)
            begin
                fa = p_side[k].tail ? erfinv_pkg::POLY_TAIL[0] : erfinv_pkg::POLY_MID[0];
                fb = p_side[k].tail ? erfinv_pkg::F_ONE : p_side[k].tl;
                fc = p_side[k].tail ? erfinv_pkg::F_NEG_ZERO : erfinv_pkg::POLY_MID[1];
            end
            else
            begin
                fa = p_res[k];
                fb = p_side[k].tl;
                fc = p_side[k].tail ? erfinv_pkg::POLY_TAIL[k] : erfinv_pkg::POLY_MID[k+1];
            end
        end

        erfinv_fma u_p (
            .clk(clk), .rst_n(rst_n), .vld_in(p_vld[k]),
            .a(fa), .b(fb), .c(fc), .side_in(p_side[k]),
            .vld_out(p_vld[k+1]), .res(p_res[k+1]), .side_out(p_side[k+1])
        );
    end

    erfinv_fma u_fin (
        .clk(clk), .rst_n(rst_n), .vld_in(p_vld[erfinv_pkg::N_TAIL]),
        .a(p_side[erfinv_pkg::N_TAIL].a), .b(p_res[erfinv_pkg::N_TAIL]),
        .c(erfinv_pkg::F_NEG_ZERO), .side_in(p_side[erfinv_pkg::N_TAIL]),
        .vld_out(done), .res(result_bits), .side_out()
    );

    // checks
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(erfinv_pkg::LATENCY) done)
        else $error("item did not complete after pipeline latency");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, erfinv_pkg::LATENCY))
        else $error("result without a matching item");

    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (operand_bits[30:0] > 31'h7F800000)) |-> ##(erfinv_pkg::LATENCY)
        (result_bits[30:22] == 9'h1FF))
        else $error("NaN item did not give a quiet NaN");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (operand_bits[30:0] == 31'd0)) |-> ##(erfinv_pkg::LATENCY)
        (result_bits == $past(operand_bits, erfinv_pkg::LATENCY)))
        else $error("signed zero item did not return itself");

endmodule

[bench/inverse_error_function_fp32_checker.sv]
// ----------------------------------------------------------------------------
// inverse_error_function_fp32_checker
// Watches the command and result ports of the erfinv core, computes the
// expected binary32 result of every accepted item bit for bit, and compares
// each strobed result with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module inverse_error_function_fp32_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] operand_bits,
    input  logic        done,
    input  logic [31:0] result_bits,
    output int          fail_count,
    output int          pending
);

    // ring of outstanding expectations, far deeper than the pipeline
    logic [31:0] expected_mem [256];
    int unsigned wr_count = 0;
    int unsigned rd_count = 0;

    function automatic bit f_nan(input logic [31:0] x);
        return x[30:0] > 31'h7F800000;
    endfunction

    function automatic bit f_inf(input logic [31:0] x);
        return x[30:0] == 31'h7F800000;
    endfunction

    function automatic bit f_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // finite nonzero x = sig * 2^ex, sig in [2^23, 2^24)
    function automatic void split_float(input logic [31:0] x, output logic [31:0] sig,
                                        output int ex);
        sig = {9'd0, x[22:0]};
        if (x[30:23] != 8'd0)
        begin
            sig[23] = 1'b1;
            ex = int'(x[30:23]) - 150;
        end
        else ex = -149;
        while (sig[23] == 1'b0)
        begin
            sig = sig << 1;
            ex--;
        end
    endfunction

    function automatic logic [31:0] round_to_f32(input logic sgn, input logic [63:0] r,
                                                 input int er);
        int biased, sh;
        logic [31:0] base, sig;
        logic [63:0] rem, half;
        while (r[63] == 1'b0)
        begin
            r = r << 1;
            er--;
        end
        biased = er + 63 + 127;
        if (biased > 254) return {sgn, 31'h7F800000};
        if (biased >= 1)
        begin
            sh = 40;
            base = 32'(biased - 1);
        end
        else
        begin
            sh = 40 + (1 - biased);
            base = 32'd0;
        end
        if (sh > 64) return {sgn, 31'd0};
        if (sh == 64)
        begin
            sig = 32'd0;
            rem = r;
            half = 64'h8000000000000000;
        end
        else
        begin
            sig = 32'(r >> sh);
            rem = r & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
        end
        if (rem > half || (rem == half && sig[0])) sig++;
        return {sgn, 31'd0} | ((base << 23) + sig);
    endfunction

    function automatic logic [31:0] fused_mul_add(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] c);
        logic sp, sc, sx, sy;
        logic [31:0] ma, mb, mc;
        int xa, xb, xc, ep, ec, ex, ey, d;
        logic [63:0] p, cv, x, y, r, lost;
        if (f_nan(a)) return a | erfinv_pkg::F_QBIT;
        if (f_nan(b)) return b | erfinv_pkg::F_QBIT;
        if (f_nan(c)) return c | erfinv_pkg::F_QBIT;
        sp = a[31] ^ b[31];
        sc = c[31];
        if (f_inf(a) || f_inf(b))
        begin
            if (f_zero(a) || f_zero(b)) return erfinv_pkg::F_QNAN;
            if (f_inf(c) && sc != sp) return erfinv_pkg::F_QNAN;
            return {sp, 31'h7F800000};
        end
        if (f_inf(c)) return c;
        if (f_zero(a) || f_zero(b))
        begin
            if (f_zero(c)) return {sp & sc, 31'd0};
            return c;
        end
        split_float(a, ma, xa);
        split_float(b, mb, xb);
        p = (64'(ma) * 64'(mb)) << 14;
        ep = xa + xb - 14;
        if (f_zero(c)) return round_to_f32(sp, p, ep);
        split_float(c, mc, xc);
        cv = 64'(mc) << 38;
        ec = xc - 38;
        if (ep >= ec)
        begin
            x = p; ex = ep; sx = sp; y = cv; ey = ec; sy = sc;
        end
        else
        begin
            x = cv; ex = ec; sx = sc; y = p; ey = ep; sy = sp;
        end
        d = ex - ey;
        if (d >= 64) y = 64'd1;
        else if (d > 0)
        begin
            lost = y & ((64'd1 << d) - 64'd1);
            y = (y >> d) | 64'(lost != 0);
        end
        if (sx == sy) r = x + y;
        else if (x >= y) r = x - y;
        else
        begin
            r = y - x;
            sx = sy;
        end
        if (r == 0) return 32'd0;
        return round_to_f32(sx, r, ex);
    endfunction

    function automatic logic [31:0] small_int_f32(input int v);
        logic s;
        logic [31:0] u;
        int p;
        if (v == 0) return 32'd0;
        s = v < 0;
        u = s ? 32'(-v) : 32'(v);
        p = 31;
        while (u[p] == 1'b0) p--;
        return {s, 8'(127 + p), 23'((u << (23 - p)) & 32'h7FFFFF)};
    endfunction

    function automatic logic [31:0] natural_log(input logic [31:0] a);
        logic [31:0] m, mq, s, r, t, fi, f;
        int e;
        if (a == 0 || a > erfinv_pkg::F_MAX)
        begin
            if (f_nan(a)) return a | erfinv_pkg::F_QBIT;
            if (f_zero(a)) return erfinv_pkg::F_NEG_INF;
            if (a[31]) return erfinv_pkg::F_QNAN;
            return erfinv_pkg::F_POS_INF;
        end
        if (a[30:23] != 8'd0)
        begin
            m = (a & 32'h7FFFFF) | 32'h3F000000;
            e = int'(a[30:23]) - 126;
        end
        else
        begin
            f = a & 32'h7FFFFF;
            e = -125;
            while (f[23] == 1'b0)
            begin
                f = f << 1;
                e--;
            end
            m = (f & 32'h7FFFFF) | 32'h3F000000;
        end
        if (m < erfinv_pkg::F_TWO_THIRDS)
        begin
            m += 32'h00800000;
            e--;
        end
        fi = small_int_f32(e);
        mq = fused_mul_add(m, erfinv_pkg::F_ONE, erfinv_pkg::F_NEG_ONE);
        s = fused_mul_add(mq, mq, erfinv_pkg::F_NEG_ZERO);
        r = fused_mul_add(erfinv_pkg::LOG_R0, s, erfinv_pkg::LOG_R1);
        t = fused_mul_add(erfinv_pkg::LOG_T0, s, erfinv_pkg::LOG_T1);
        r = fused_mul_add(r, s, erfinv_pkg::LOG_R2);
        t = fused_mul_add(t, s, erfinv_pkg::LOG_T2);
        r = fused_mul_add(r, s, erfinv_pkg::LOG_R3);
        r = fused_mul_add(t, mq, r);
        r = fused_mul_add(r, mq, erfinv_pkg::F_L_THIRD);
        r = fused_mul_add(r, mq, erfinv_pkg::F_HALF_NEG);
        r = fused_mul_add(r, s, mq);
        return fused_mul_add(fi, erfinv_pkg::F_LN2, r);
    endfunction

    function automatic logic [31:0] erfinv_f32(input logic [31:0] a);
        logic [31:0] na, t, p;
        na = fused_mul_add(32'd0, erfinv_pkg::F_ONE, a ^ 32'h80000000);
        t = fused_mul_add(a, na, erfinv_pkg::F_ONE);
        t = natural_log(t);
        // tail branch also covers an infinite log
        if (t[30:0] > erfinv_pkg::F_SPLIT[30:0] && t[30:0] <= erfinv_pkg::F_POS_INF[30:0])
        begin
            p = erfinv_pkg::POLY_TAIL[0];
            for (int k = 1; k < erfinv_pkg::N_TAIL; k++)
                p = fused_mul_add(p, t, erfinv_pkg::POLY_TAIL[k]);
        end
        else
        begin
            p = erfinv_pkg::POLY_MID[0];
            for (int k = 1; k < erfinv_pkg::N_MID; k++)
                p = fused_mul_add(p, t, erfinv_pkg::POLY_MID[k]);
        end
        return fused_mul_add(a, p, erfinv_pkg::F_NEG_ZERO);
    endfunction

    assign pending = int'(wr_count - rd_count);

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            wr_count = 0;
            rd_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (wr_count == rd_count)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %h with no item outstanding", result_bits);
                end
                else
                begin
                    want = expected_mem[rd_count[7:0]];
                    rd_count++;
                    if (result_bits !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %h actual %h", want,
                                     result_bits);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_mem[wr_count[7:0]] = erfinv_f32(operand_bits);
                wr_count++;
            end
        end
    end

endmodule

[bench/inverse_error_function_fp32_core_test.sv]
// ----------------------------------------------------------------------------
// inverse_error_function_fp32_core_test
// Drives directed special operands and random binary32 items with random
// gaps into the erfinv core; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module inverse_error_function_fp32_core_test;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] operand_bits;
    logic        done;
    logic [31:0] result_bits;
    int          fail_count;
    int          pending;

    localparam logic [31:0] DIRECTED [22] = '{
        32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h7F800000,
        32'hFF800000, 32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h00000001,
        32'h80000001, 32'h007FFFFF, 32'h3F7FFFFF, 32'hBF7FFFFF, 32'h3F800001,
        32'h7F7FFFFF, 32'h3F000000, 32'h3F7FF000, 32'h3E800000, 32'h33800000,
        32'hBF3504F3, 32'h3F7FFFC0
    };

    inverse_error_function_fp32_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand_bits (operand_bits),
        .done         (done),
        .result_bits  (result_bits)
    );

    inverse_error_function_fp32_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand_bits (operand_bits),
        .done         (done),
        .result_bits  (result_bits),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    function automatic logic [31:0] pick_operand();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return {1'($urandom), 8'($urandom_range(90, 126)), 23'($urandom)};
        if (roll < 75) return {1'($urandom), 8'd126, 7'h7F, 16'($urandom)};
        return $urandom;
    endfunction

    // start drops only after a gap decision, so it never toggles twice in a step
    task automatic send_item(input logic [31:0] v, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        operand_bits <= v;
        #1;
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operand_bits = 32'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 22; i++) send_item(DIRECTED[i], (i % 3 == 2) ? 2 : 0);
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        for (int i = 0; i < 650; i++)
        begin
            if (i >= 300 && i < 340) send_item(pick_operand(), 0);
            else send_item(pick_operand(), pick_gap());
        end
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (erfinv_pkg::LATENCY + 10) @(posedge clk);
        if (fail_count == 0) $display("inverse_error_function_fp32_core verification clean");
        else $display("inverse_error_function_fp32_core verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("inverse_error_function_fp32_core verification failed");
        $finish;
    end

endmodule
